FILE: rtl/char_lcd_nibble_bus_controller_defines.svh
// assertion macros for the lcd nibble bus controller rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CHAR_LCD_NIBBLE_BUS_CONTROLLER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_BUS_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LCDNB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define LCDNB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LCDNB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LCDNB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/lcdnb_pkg.sv
// types and constants of the lcd nibble bus controller
// no dependencies; imported by every rtl module of the block
package lcdnb_pkg;

    localparam int CFG_W = 24;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CMD    = 2'd1,
        OP_DATA   = 2'd2,
        OP_CURSOR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_ENABLE_PULSE = 2'd0,
        CFG_POWERUP_WAIT = 2'd1,
        CFG_LONG_GAP     = 2'd2,
        CFG_SHORT_GAP    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_WAIT     = 4'd1,
        PH_INIT_HI  = 4'd2,
        PH_INIT_LO  = 4'd3,
        PH_POLL1_HI = 4'd4,
        PH_POLL1_LO = 4'd5,
        PH_POLL2_HI = 4'd6,
        PH_POLL2_LO = 4'd7,
        PH_WRH_HI   = 4'd8,
        PH_WRH_LO   = 4'd9,
        PH_WRL_HI   = 4'd10,
        PH_WRL_LO   = 4'd11
    } phase_t;

    // init step codes
    localparam logic [2:0] INIT_OFF      = 3'd0;
    localparam logic [2:0] INIT_FIRST    = 3'd1;
    localparam logic [2:0] INIT_LAST_NIB = 3'd4;
    localparam logic [2:0] INIT_POLL     = 3'd5;
    localparam logic [2:0] INIT_CMDS     = 3'd6;

    // init command bytes
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic       CURSOR_CMD_BIT = 1'b1;

    localparam logic [3:0] NIB_INIT = 4'h3;
    localparam logic [3:0] NIB_4BIT = 4'h2;

    localparam logic [7:0] RST_ENABLE_PULSE = 8'd20;
    localparam logic [23:0] RST_POWERUP_WAIT = 24'd300000;
    localparam logic [23:0] RST_LONG_GAP     = 24'd120000;
    localparam logic [23:0] RST_SHORT_GAP    = 24'd40000;

    typedef struct packed {
        logic       request_valid;
        logic [1:0] operation;
        logic [7:0] value;
        logic [5:0] column;
        logic       row;
        logic [3:0] bus_in;
    } in_t;

    typedef struct packed {
        logic       reg_select;
        logic       read_not_write;
        logic       enable_pin;
        logic [3:0] bus_out;
        logic       bus_drive;
        logic       ready_res;
    } out_t;

    typedef struct packed {
        logic [7:0]       enable_pulse;
        logic [CFG_W-1:0] powerup_wait;
        logic [CFG_W-1:0] long_gap;
        logic [CFG_W-1:0] short_gap;
    } timing_t;

    // classified beat as held in the queue
    typedef struct packed {
        logic       req;
        logic       is_init;
        logic [7:0] byte_val;
        logic       sel;
        logic [3:0] bus;
    } cls_t;

    typedef struct packed {
        logic avail;
        cls_t item;
    } q_head_t;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       e;
        logic [3:0] nib;
        logic       drive;
    } pins_t;

endpackage

FILE: rtl/lcdnb_front.sv
// front end: accepts input beats, classifies requests, holds them in a short queue
// depends on lcdnb_pkg
module lcdnb_front
    import lcdnb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  in_t     in_data,
    output q_head_t head,
    input  logic    pop
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);

    cls_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    cls_t             cls;
    logic             push;
    logic             do_pop;

    // classify the beat into byte and register select
    always_comb
    begin
        cls.req     = in_data.request_valid;
        cls.is_init = (op_t'(in_data.operation) == OP_INIT);
        cls.sel     = (op_t'(in_data.operation) == OP_DATA);
        cls.bus     = in_data.bus_in;
        if (op_t'(in_data.operation) == OP_CURSOR)
            cls.byte_val = {CURSOR_CMD_BIT, in_data.row, in_data.column};
        else
            cls.byte_val = in_data.value;
    end

    assign in_stall = (count_reg == (PTR_W+1)'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cls;
    end

    assign head.avail = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/lcdnb_back.sv
// back end: pin sequencer stepping one tick per beat, plus the output register
// depends on lcdnb_pkg and the assertion macro header
`include "char_lcd_nibble_bus_controller_defines.svh"

module lcdnb_back
    import lcdnb_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  timing_t timing,
    input  q_head_t head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_stall,
    output out_t    out_data
);

    localparam int CW = COUNT_WIDTH;

    phase_t     phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_sel_reg, pend_sel_next;
    logic [2:0] init_step_reg, init_step_next;
    logic [3:0] status_reg, status_next;
    pins_t      pins_reg, pins_next;
    logic       out_valid_reg, out_valid_next;
    out_t       out_data_reg, out_data_next;
    logic       ready;
    logic [CFG_W-1:0] pulse_ext;

    function automatic logic [CW-1:0] span(input logic [CFG_W-1:0] n);
        logic [CW-1:0] t;
        t = CW'(n);
        return (t == '0) ? CW'(1) : t;
    endfunction

    assign pulse_ext = CFG_W'(timing.enable_pulse);
    assign pop       = head.avail && (!out_valid_reg || !out_stall);
    assign ready     = (phase_reg == PH_IDLE);

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        pend_byte_next = pend_byte_reg;
        pend_sel_next  = pend_sel_reg;
        init_step_next = init_step_reg;
        status_next    = status_reg;
        pins_next      = pins_reg;

        // request takes effect in its own tick
        if (pop && ready && head.item.req)
        begin
            init_step_next = INIT_OFF;
            if (head.item.is_init)
            begin
                init_step_next = INIT_FIRST;
                phase_next     = PH_WAIT;
                cnt_next       = span(timing.powerup_wait);
            end
            else
            begin
                pend_byte_next = head.item.byte_val;
                pend_sel_next  = head.item.sel;
                phase_next     = PH_POLL1_HI;
                cnt_next       = span(pulse_ext);
            end
        end

        if (pop && phase_next != PH_IDLE)
        begin
            // pin levels for this tick
            unique case (phase_next)
                PH_WAIT:
                begin
                    pins_next.rs    = 1'b0;
                    pins_next.rw    = 1'b0;
                    pins_next.e     = 1'b0;
                    pins_next.drive = 1'b1;
                end
                PH_INIT_HI, PH_INIT_LO:
                begin
                    pins_next.rs    = 1'b0;
                    pins_next.rw    = 1'b0;
                    pins_next.e     = (phase_next == PH_INIT_HI);
                    pins_next.nib   = (init_step_next == INIT_LAST_NIB) ? NIB_4BIT : NIB_INIT;
                    pins_next.drive = 1'b1;
                end
                PH_POLL1_HI, PH_POLL2_HI, PH_POLL1_LO, PH_POLL2_LO:
                begin
                    pins_next.rs    = 1'b0;
                    pins_next.rw    = 1'b1;
                    pins_next.e     = (phase_next == PH_POLL1_HI) || (phase_next == PH_POLL2_HI);
                    pins_next.nib   = '0;
                    pins_next.drive = 1'b0;
                end
                PH_WRH_HI, PH_WRH_LO, PH_WRL_HI, PH_WRL_LO:
                begin
                    pins_next.rs    = pend_sel_next;
                    pins_next.rw    = 1'b0;
                    pins_next.e     = (phase_next == PH_WRH_HI) || (phase_next == PH_WRL_HI);
                    pins_next.nib   = ((phase_next == PH_WRH_HI) || (phase_next == PH_WRH_LO))
                                      ? pend_byte_next[7:4] : pend_byte_next[3:0];
                    pins_next.drive = 1'b1;
                end
                default:
                begin
                    pins_next = pins_reg;
                end
            endcase

            // busy flag sampled in the last e-high tick of the first read
            if (phase_next == PH_POLL1_HI && cnt_next <= CW'(1))
                status_next = head.item.bus;

            cnt_next = cnt_next - 1'b1;

            if (cnt_next == '0)
            begin
                unique case (phase_next)
                    PH_WAIT:
                    begin
                        phase_next = PH_INIT_HI;
                        cnt_next   = span(pulse_ext);
                    end
                    PH_INIT_HI:
                    begin
                        phase_next = PH_INIT_LO;
                        cnt_next   = span(pulse_ext);
                    end
                    PH_INIT_LO:
                    begin
                        if (init_step_next < INIT_LAST_NIB)
                        begin
                            phase_next     = PH_WAIT;
                            cnt_next       = (init_step_next == INIT_FIRST)
                                             ? span(timing.long_gap) : span(timing.short_gap);
                            init_step_next = init_step_next + 1'b1;
                        end
                        else
                        begin
                            init_step_next = INIT_POLL;
                            phase_next     = PH_POLL1_HI;
                            cnt_next       = span(pulse_ext);
                        end
                    end
                    PH_POLL1_HI:
                    begin
                        phase_next = PH_POLL1_LO;
                        cnt_next   = span(pulse_ext);
                    end
                    PH_POLL1_LO:
                    begin
                        phase_next = PH_POLL2_HI;
                        cnt_next   = span(pulse_ext);
                    end
                    PH_POLL2_HI:
                    begin
                        phase_next = PH_POLL2_LO;
                        cnt_next   = span(pulse_ext);
                    end
                    PH_POLL2_LO:
                    begin
                        priority if (status_next[3])
                        begin
                            phase_next = PH_POLL1_HI;
                            cnt_next   = span(pulse_ext);
                        end
                        else if (init_step_next == INIT_POLL)
                        begin
                            init_step_next = INIT_CMDS;
                            pend_byte_next = CMD_FUNC_SET;
                            pend_sel_next  = 1'b0;
                            phase_next     = PH_POLL1_HI;
                            cnt_next       = span(pulse_ext);
                        end
                        else
                        begin
                            phase_next = PH_WRH_HI;
                            cnt_next   = span(pulse_ext);
                        end
                    end
                    PH_WRH_HI:
                    begin
                        phase_next = PH_WRH_LO;
                        cnt_next   = span(pulse_ext);
                    end
                    PH_WRH_LO:
                    begin
                        phase_next = PH_WRL_HI;
                        cnt_next   = span(pulse_ext);
                    end
                    PH_WRL_HI:
                    begin
                        phase_next = PH_WRL_LO;
                        cnt_next   = span(pulse_ext);
                    end
                    PH_WRL_LO:
                    begin
                        if (init_step_next == INIT_CMDS && pend_byte_next != CMD_ENTRY_MODE)
                        begin
                            priority if (pend_byte_next == CMD_FUNC_SET)
                                pend_byte_next = CMD_DISP_OFF;
                            else if (pend_byte_next == CMD_DISP_OFF)
                                pend_byte_next = CMD_CLEAR;
                            else
                                pend_byte_next = CMD_ENTRY_MODE;
                            pend_sel_next = 1'b0;
                            phase_next    = PH_POLL1_HI;
                            cnt_next      = span(pulse_ext);
                        end
                        else
                        begin
                            init_step_next = INIT_OFF;
                            phase_next     = PH_IDLE;
                            cnt_next       = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                    end
                endcase
            end
        end

        // output register
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next               = 1'b1;
            out_data_next.reg_select     = pins_next.rs;
            out_data_next.read_not_write = pins_next.rw;
            out_data_next.enable_pin     = pins_next.e;
            out_data_next.bus_out        = pins_next.nib;
            out_data_next.bus_drive      = pins_next.drive;
            out_data_next.ready_res      = ready;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            pend_byte_reg <= '0;
            pend_sel_reg  <= 1'b0;
            init_step_reg <= INIT_OFF;
            status_reg    <= '0;
            pins_reg      <= '{rs: 1'b0, rw: 1'b0, e: 1'b0, nib: 4'h0, drive: 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            pend_byte_reg <= pend_byte_next;
            pend_sel_reg  <= pend_sel_next;
            init_step_reg <= init_step_next;
            status_reg    <= status_next;
            pins_reg      <= pins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LCDNB_ASSERT_IMPL(a_idle_cnt_zero, clk, rst_n, phase_reg == PH_IDLE, cnt_reg == '0, "idle with a running tick counter")
    `LCDNB_ASSERT_IMPL(a_busy_cnt_live, clk, rst_n, phase_reg != PH_IDLE, cnt_reg != '0, "active phase with an expired tick counter")
    `LCDNB_ASSERT_IMPL(a_init_step_range, clk, rst_n, 1'b1, init_step_reg <= INIT_CMDS, "init step out of range")
    `LCDNB_ASSERT_IMPL(a_init_cmds_instr, clk, rst_n, init_step_reg == INIT_CMDS, !pend_sel_reg, "init command marked as data")
    `LCDNB_ASSERT_NEXT(a_no_step_no_change, clk, rst_n, !pop, $stable(phase_reg) && $stable(cnt_reg), "sequencer moved without a beat")

endmodule

FILE: rtl/char_lcd_nibble_bus_controller.sv
// top level of the character lcd controller on a 4-bit nibble bus
// depends on lcdnb_pkg, lcdnb_front and lcdnb_back
//
// usage
//  - input channel (in_valid / in_stall / in_data): one beat per lcd tick, carrying
//    the sampled DB7..DB4 lines and an optional request (initialise, command byte,
//    data byte or cursor move); a request is only taken if the sequencer is idle
//    in that tick, otherwise it is dropped
//  - output channel (out_valid / out_stall / out_data): exactly one beat per input
//    beat, in order, giving RS, RW, E, the driven nibble, bus drive and ready_res
//  - configuration: cfg_write with cfg_index / cfg_data sets the strobe width and
//    the three init waits; write only while no beats are in flight
//  - path: an accepted beat is held in the queue, then in the output register;
//    throughput one beat per cycle while out_stall allows; the back end steps the
//    sequencer once per beat
//  - a two-entry queue between front and back absorbs output stalls; in_stall
//    rises only when that queue is full
//  - reset: sequencer idle, pins all low with the bus driven, timing registers at
//    their defaults, queue and output register empty
module char_lcd_nibble_bus_controller
    import lcdnb_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data
);

    timing_t timing_reg, timing_next;
    q_head_t head;
    logic    pop;

    // timing registers, written one at a time
    always_comb
    begin
        timing_next = timing_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE_PULSE: timing_next.enable_pulse = cfg_data[7:0];
                CFG_POWERUP_WAIT: timing_next.powerup_wait = cfg_data;
                CFG_LONG_GAP:     timing_next.long_gap     = cfg_data;
                CFG_SHORT_GAP:    timing_next.short_gap    = cfg_data;
                default:          timing_next              = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg <= '{enable_pulse: RST_ENABLE_PULSE,
                            powerup_wait: RST_POWERUP_WAIT,
                            long_gap:     RST_LONG_GAP,
                            short_gap:    RST_SHORT_GAP};
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    // front: accept and classify beats into the queue
    lcdnb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .head     (head),
        .pop      (pop)
    );

    // back: step the pin sequencer once per beat and register the pins
    lcdnb_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .timing    (timing_reg),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: test/tb.sv
// self-checking testbench for char_lcd_nibble_bus_controller
// depends on lcdnb_pkg and the controller rtl; predicts every pin beat and compares
// directed init, command, data and cursor sequences, then random ticks, mostly under backpressure
module tb;
    import lcdnb_pkg::*;

    // watchdog: cycles with no beat moving on either channel
    localparam int WATCHDOG_LIMIT = 1000;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    in_t              in_data;
    logic             out_valid;
    logic             out_stall;
    out_t             out_data;

    char_lcd_nibble_bus_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // sequencer predictor: own copy of timing registers and lcd state
    // ------------------------------------------------------------------
    logic [23:0] pulse_ticks;
    logic [23:0] powerup_ticks;
    logic [23:0] long_gap;
    logic [23:0] short_gap;

    phase_t      seq_phase;
    logic [23:0] seq_count;
    logic [7:0]  pend_byte;
    logic        pend_sel;
    logic [2:0]  init_stage;
    logic [3:0]  status_nib;
    pins_t       held_pins;

    // pin beats still owed by the block, oldest first
    out_t pin_beats_due[$];

    // run statistics
    int mismatch_count;
    int beats_checked;
    int requests_taken;
    int requests_dropped;
    int busy_repolls;
    int inits_done;
    int stuck_cycles;
    int input_blocked_cycles;

    // stimulus shaping
    bit steady_mode;
    int holdoff_request;

    // a programmed duration of zero still lasts one tick
    function automatic logic [23:0] span_of(input logic [23:0] n);
        return (n == '0) ? 24'd1 : n;
    endfunction

    function automatic void enter_phase(phase_t p, logic [23:0] n);
        seq_phase = p;
        seq_count = span_of(n);
    endfunction

    function automatic void start_poll();
        enter_phase(PH_POLL1_HI, pulse_ticks);
    endfunction

    // move to the next phase once the tick counter has run out
    function automatic void advance_phase();
        case (seq_phase)
            PH_WAIT:     enter_phase(PH_INIT_HI, pulse_ticks);
            PH_INIT_HI:  enter_phase(PH_INIT_LO, pulse_ticks);
            PH_INIT_LO:
            begin
                if (init_stage < INIT_LAST_NIB)
                begin
                    enter_phase(PH_WAIT, (init_stage == INIT_FIRST) ? long_gap : short_gap);
                    init_stage = init_stage + 3'd1;
                end
                else
                begin
                    init_stage = INIT_POLL;
                    start_poll();
                end
            end
            PH_POLL1_HI: enter_phase(PH_POLL1_LO, pulse_ticks);
            PH_POLL1_LO: enter_phase(PH_POLL2_HI, pulse_ticks);
            PH_POLL2_HI: enter_phase(PH_POLL2_LO, pulse_ticks);
            PH_POLL2_LO:
            begin
                if (status_nib[3])
                begin
                    busy_repolls++;
                    start_poll();
                end
                else if (init_stage == INIT_POLL)
                begin
                    init_stage = INIT_CMDS;
                    pend_byte  = CMD_FUNC_SET;
                    pend_sel   = 1'b0;
                    start_poll();
                end
                else
                begin
                    enter_phase(PH_WRH_HI, pulse_ticks);
                end
            end
            PH_WRH_HI:   enter_phase(PH_WRH_LO, pulse_ticks);
            PH_WRH_LO:   enter_phase(PH_WRL_HI, pulse_ticks);
            PH_WRL_HI:   enter_phase(PH_WRL_LO, pulse_ticks);
            PH_WRL_LO:
            begin
                if (init_stage == INIT_CMDS && pend_byte != CMD_ENTRY_MODE)
                begin
                    // init command chain: function set, display off, clear, entry mode
                    if (pend_byte == CMD_FUNC_SET)
                        pend_byte = CMD_DISP_OFF;
                    else if (pend_byte == CMD_DISP_OFF)
                        pend_byte = CMD_CLEAR;
                    else
                        pend_byte = CMD_ENTRY_MODE;
                    pend_sel = 1'b0;
                    start_poll();
                end
                else
                begin
                    if (init_stage == INIT_CMDS)
                        inits_done++;
                    init_stage = INIT_OFF;
                    seq_phase  = PH_IDLE;
                    seq_count  = '0;
                end
            end
            default:
            begin
                seq_phase = PH_IDLE;
                seq_count = '0;
            end
        endcase
    endfunction

    // pin levels that the current phase puts out
    function automatic pins_t phase_pins();
        pins_t p;
        p = '0;
        case (seq_phase)
            PH_WAIT:
            begin
                // init waits keep the last nibble on the bus, strobe low
                p.nib   = held_pins.nib;
                p.drive = 1'b1;
            end
            PH_INIT_HI, PH_INIT_LO:
            begin
                p.nib   = (init_stage == INIT_LAST_NIB) ? NIB_4BIT : NIB_INIT;
                p.drive = 1'b1;
                p.e     = (seq_phase == PH_INIT_HI);
            end
            PH_POLL1_HI, PH_POLL2_HI:
            begin
                p.rw = 1'b1;
                p.e  = 1'b1;
            end
            PH_POLL1_LO, PH_POLL2_LO:
                p.rw = 1'b1;
            PH_WRH_HI, PH_WRH_LO, PH_WRL_HI, PH_WRL_LO:
            begin
                p.nib   = (seq_phase == PH_WRH_HI || seq_phase == PH_WRH_LO) ?
                          pend_byte[7:4] : pend_byte[3:0];
                p.rs    = pend_sel;
                p.drive = 1'b1;
                p.e     = (seq_phase == PH_WRH_HI || seq_phase == PH_WRL_HI);
            end
            default:
                p = held_pins;
        endcase
        return p;
    endfunction

    // one lcd tick: take a request if idle, step the sequencer, give the pin beat
    function automatic out_t lcd_tick(in_t beat);
        out_t  res;
        logic  ready;
        ready = (seq_phase == PH_IDLE);
        if (beat.request_valid && !ready)
            requests_dropped++;
        if (ready && beat.request_valid)
        begin
            requests_taken++;
            init_stage = INIT_OFF;
            case (op_t'(beat.operation))
                OP_INIT:
                begin
                    init_stage = INIT_FIRST;
                    enter_phase(PH_WAIT, powerup_ticks);
                end
                OP_CMD:
                begin
                    pend_byte = beat.value;
                    pend_sel  = 1'b0;
                    start_poll();
                end
                OP_DATA:
                begin
                    pend_byte = beat.value;
                    pend_sel  = 1'b1;
                    start_poll();
                end
                default:
                begin
                    pend_byte = {CURSOR_CMD_BIT, beat.row, beat.column};
                    pend_sel  = 1'b0;
                    start_poll();
                end
            endcase
        end
        if (seq_phase != PH_IDLE)
        begin
            held_pins = phase_pins();
            // busy flag is sampled in the last strobe-high tick of the first read
            if (seq_phase == PH_POLL1_HI && seq_count <= 24'd1)
                status_nib = beat.bus_in;
            if (seq_count != '0)
                seq_count--;
            if (seq_count == '0)
                advance_phase();
        end
        res.reg_select     = held_pins.rs;
        res.read_not_write = held_pins.rw;
        res.enable_pin     = held_pins.e;
        res.bus_out        = held_pins.nib;
        res.bus_drive      = held_pins.drive;
        res.ready_res      = ready;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // clock, checking and watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // every output beat is compared with the oldest prediction
    always @(posedge clk)
    begin : pin_checker
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pin_beats_due.size() == 0)
                report_mismatch("output beat with nothing outstanding");
            else
            begin
                want = pin_beats_due.pop_front();
                check_field("reg_select", 4'(out_data.reg_select), 4'(want.reg_select));
                check_field("read_not_write", 4'(out_data.read_not_write),
                            4'(want.read_not_write));
                check_field("enable_pin", 4'(out_data.enable_pin), 4'(want.enable_pin));
                check_field("bus_out", out_data.bus_out, want.bus_out);
                check_field("bus_drive", 4'(out_data.bus_drive), 4'(want.bus_drive));
                check_field("ready_res", 4'(out_data.ready_res), 4'(want.ready_res));
                beats_checked++;
            end
        end
    end

    // stops a hung run; also counts cycles where the input is held off
    always @(posedge clk)
    begin
        if (in_valid && in_stall)
            input_blocked_cycles++;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", stuck_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts, or one long hold-off when a test asks for it
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_request > 0)
            begin
                out_stall = 1'b1;
                repeat (holdoff_request) @(negedge clk);
                holdoff_request = 0;
                out_stall = 1'b0;
            end
            else if (!steady_mode && rst_n && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one beat with no request; random fields, busy flag set with the given odds
    function automatic in_t noise_beat(input int busy_pct);
        in_t b;
        b.request_valid = 1'b0;
        b.operation     = 2'($urandom_range(0, 3));
        b.value         = 8'($urandom_range(0, 255));
        b.column        = 6'($urandom_range(0, 63));
        b.row           = 1'($urandom_range(0, 1));
        b.bus_in        = 4'($urandom_range(0, 15));
        b.bus_in[3]     = ($urandom_range(0, 99) < busy_pct);
        return b;
    endfunction

    // send one tick beat, with an occasional sender gap, and predict its pins
    task automatic send_beat(input in_t beat);
        @(negedge clk);
        if (!steady_mode && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_data  = beat;
        in_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pin_beats_due.push_back(lcd_tick(beat));
    endtask

    task automatic offer_request(input op_t op, input logic [7:0] val,
                                 input logic [5:0] col, input logic r);
        in_t b;
        b = noise_beat(0);
        b.request_valid = 1'b1;
        b.operation     = op;
        b.value         = val;
        b.column        = col;
        b.row           = r;
        send_beat(b);
    endtask

    task automatic idle_ticks(input int n, input int busy_pct);
        repeat (n) send_beat(noise_beat(busy_pct));
    endtask

    // sender stops and waits until every owed beat has come out
    task automatic wait_for_outputs();
        @(negedge clk);
        in_valid = 1'b0;
        while (pin_beats_due.size() != 0)
            @(posedge clk);
    endtask

    // clock the sequencer with the busy flag clear until it is back to idle
    task automatic settle_sequencer();
        while (seq_phase != PH_IDLE)
            send_beat(noise_beat(0));
        wait_for_outputs();
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [23:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_ENABLE_PULSE: pulse_ticks   = {16'd0, data[7:0]};
            CFG_POWERUP_WAIT: powerup_ticks = data;
            CFG_LONG_GAP:     long_gap      = data;
            default:          short_gap     = data;
        endcase
    endtask

    task automatic set_timing(input logic [7:0] pulse, input logic [23:0] powerup,
                              input logic [23:0] lgap, input logic [23:0] sgap);
        settle_sequencer();
        write_register(CFG_ENABLE_PULSE, {16'd0, pulse});
        write_register(CFG_POWERUP_WAIT, powerup);
        write_register(CFG_LONG_GAP, lgap);
        write_register(CFG_SHORT_GAP, sgap);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // pins straight after reset, one command at the default strobe width,
    // and a request dropped because the sequencer is busy
    task automatic test_reset_defaults();
        idle_ticks(4, 30);
        offer_request(OP_CMD, 8'hFF, 6'd0, 1'b0);
        idle_ticks(3, 0);
        offer_request(OP_DATA, 8'h00, 6'd63, 1'b1);
        settle_sequencer();
    endtask

    // init with every duration zero (one tick each), then every duration one
    task automatic test_zero_and_unit_timing();
        set_timing(8'd0, 24'd0, 24'd0, 24'd0);
        offer_request(OP_INIT, 8'h00, 6'd0, 1'b0);
        settle_sequencer();
        set_timing(8'd1, 24'd1, 24'd1, 24'd1);
        offer_request(OP_INIT, 8'hFF, 6'd63, 1'b1);
        idle_ticks(20, 0);
        settle_sequencer();
    endtask

    // each operation with extreme bytes and cursor positions; busy flag held for a while
    task automatic test_operations();
        set_timing(8'd1, 24'd5, 24'd3, 24'd2);
        offer_request(OP_CMD, 8'h00, 6'd63, 1'b1);
        idle_ticks(12, 100);
        settle_sequencer();
        offer_request(OP_DATA, 8'hFF, 6'd0, 1'b0);
        settle_sequencer();
        offer_request(OP_DATA, 8'h00, 6'd21, 1'b1);
        settle_sequencer();
        offer_request(OP_CURSOR, 8'hFF, 6'd63, 1'b1);
        settle_sequencer();
        offer_request(OP_CURSOR, 8'h00, 6'd0, 1'b0);
        settle_sequencer();
        offer_request(OP_CMD, 8'hA5, 6'd42, 1'b0);
        idle_ticks(6, 50);
        settle_sequencer();
        // init with the busy flag up during the polls
        offer_request(OP_INIT, 8'h5A, 6'd17, 1'b1);
        idle_ticks(30, 60);
        settle_sequencer();
    endtask

    // a wider strobe, and an init with longer and distinct waits
    task automatic test_wide_timing();
        set_timing(8'd5, 24'd3, 24'd3, 24'd3);
        offer_request(OP_DATA, 8'h5A, 6'd5, 1'b0);
        settle_sequencer();
        set_timing(8'd1, 24'd12, 24'd8, 24'd4);
        offer_request(OP_INIT, 8'h00, 6'd0, 1'b0);
        settle_sequencer();
    endtask

    // long receiver hold-off so the block fills and stalls its input,
    // then a sender pause in the middle of a byte until all beats are out
    task automatic test_backpressure();
        set_timing(8'd1, 24'd3, 24'd2, 24'd1);
        holdoff_request = 60;
        offer_request(OP_DATA, 8'hC3, 6'd0, 1'b0);
        idle_ticks(30, 20);
        offer_request(OP_CURSOR, 8'h00, 6'd40, 1'b1);
        idle_ticks(3, 0);
        wait_for_outputs();
        idle_ticks(10, 20);
        settle_sequencer();
    endtask

    // random ticks: mostly well-formed requests when idle, some dropped ones when busy
    task automatic random_round(input int beats);
        in_t b;
        repeat (beats)
        begin
            b = noise_beat(20);
            if (seq_phase == PH_IDLE)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    b.request_valid = 1'b1;
                    b.operation = ($urandom_range(0, 9) == 0) ? OP_INIT
                                                              : op_t'(2'($urandom_range(1, 3)));
                end
            end
            else if ($urandom_range(0, 19) == 0)
                b.request_valid = 1'b1;
            send_beat(b);
        end
    endtask

    task automatic test_random();
        logic [7:0] pulse;
        for (int round = 0; round < 4; round++)
        begin
            pulse = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8))
                                                : 8'($urandom_range(1, 3));
            set_timing(pulse, 24'($urandom_range(0, 12)), 24'($urandom_range(0, 12)),
                       24'($urandom_range(0, 12)));
            // no idling on either side in the last round
            if (round == 3)
                steady_mode = 1'b1;
            random_round(30);
        end
        settle_sequencer();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_ENABLE_PULSE;
        cfg_data        = '0;
        in_valid        = 1'b0;
        in_data         = '0;
        steady_mode     = 1'b0;
        holdoff_request = 0;

        // predictor reset state
        pulse_ticks   = {16'd0, RST_ENABLE_PULSE};
        powerup_ticks = RST_POWERUP_WAIT;
        long_gap      = RST_LONG_GAP;
        short_gap     = RST_SHORT_GAP;
        seq_phase     = PH_IDLE;
        seq_count     = '0;
        pend_byte     = '0;
        pend_sel      = 1'b0;
        init_stage    = INIT_OFF;
        status_nib    = '0;
        held_pins     = '{rs: 1'b0, rw: 1'b0, e: 1'b0, nib: 4'h0, drive: 1'b1};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_zero_and_unit_timing();
        test_operations();
        test_wide_timing();
        test_backpressure();
        test_random();

        // drain and allow for the two-stage pipeline to go quiet
        wait_for_outputs();
        repeat (10) @(posedge clk);
        if (pin_beats_due.size() != 0)
            report_mismatch($sformatf("%0d pin beats never came out", pin_beats_due.size()));

        $display("run: %0d pin beats checked, %0d requests taken, %0d dropped while busy",
                 beats_checked, requests_taken, requests_dropped);
        $display("run: %0d inits completed, %0d busy repolls, %0d input-stalled cycles",
                 inits_done, busy_repolls, input_blocked_cycles);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
